FILE: design/vlcr_pkg.sv
// ----------------------------------------------------------------------------
// vlcr_pkg
// Shared types and constants of the vehicle light command repeater: opcodes,
// sequencer states, channel numbers and the structs passed between modules.
// ----------------------------------------------------------------------------
package vlcr_pkg;

  localparam int unsigned NumLights = 6;
  localparam int unsigned ChW       = 3;
  localparam int unsigned CntW      = 8;

  localparam logic [ChW-1:0]  ChRight     = 3'd3;
  localparam logic [ChW-1:0]  ChLeft      = 3'd4;
  localparam logic [ChW-1:0]  ChHazard    = 3'd5;
  localparam logic [ChW-1:0]  ChLast      = 3'd5;
  localparam logic [CntW-1:0] ResetRepeat = 8'd2;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_SCAN,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    opcode_e        opcode;
    logic [ChW-1:0] light_channel;
    logic           light_value;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] out_channel;
    logic           out_value;
    logic           last_of_tick;
  } out_item_t;

  // Commands from the sequencer to the channel bank.
  typedef struct packed {
    logic           set_en;
    logic [ChW-1:0] set_ch;
    logic           set_val;
    logic           dec_en;
    logic [ChW-1:0] dec_idx;
  } bank_cmd_t;

  // Status from the channel bank to the sequencer.
  typedef struct packed {
    logic [NumLights-1:0] lit;
    logic [NumLights-1:0] nz;
  } bank_stat_t;

endpackage

FILE: design/vlcr_if.sv
// ----------------------------------------------------------------------------
// vlcr_if
// Valid/ready channel interfaces: command input, result output and the
// repeat-count write port.
// ----------------------------------------------------------------------------
interface vlcr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] light_channel;
  logic       light_value;

  modport source (output valid, output opcode, output light_channel,
                  output light_value, input ready);
  modport sink   (input valid, input opcode, input light_channel,
                  input light_value, output ready);
endinterface

interface vlcr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_channel;
  logic       out_value;
  logic       last_of_tick;

  modport source (output valid, output out_channel, output out_value,
                  output last_of_tick, input ready);
  modport sink   (input valid, input out_channel, input out_value,
                  input last_of_tick, output ready);
endinterface

interface vlcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] repeat_count;

  modport source (output valid, output repeat_count, input ready);
  modport sink   (input valid, input repeat_count, output ready);
endinterface

FILE: design/vehicle_light_command_repeater_top.sv
// ----------------------------------------------------------------------------
// vehicle_light_command_repeater_top
// Repeats changed light commands of six vehicle lights for a configurable
// number of ticks.
//
//   Channel   Direction  Beat contents
//   in_if     sink       opcode, light_channel, light_value
//   out_if    source     out_channel, out_value, last_of_tick
//   cfg_if    sink       repeat_count
//
// A set request is accepted in the idle state and applied to the bank in the
// set state, after which ready returns. A tick is accepted, then the scan
// steps one channel per cycle up to the last one with a pending repeat (all
// six when none is pending), pausing in the emit state for each result beat;
// the single decrement unit and the scan counter set this.
// Output stalls extend a tick by the stalled cycles; no new command is taken
// until the tick is done. Reset clears all lights, all counters and sets the
// repeat count to two. Configuration is always ready.
// ----------------------------------------------------------------------------
module vehicle_light_command_repeater_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vlcr_in_if.sink     in_if,
  vlcr_out_if.source  out_if,
  vlcr_cfg_if.sink    cfg_if
);

  logic [vlcr_pkg::CntW-1:0] repeat_count_q;
  vlcr_pkg::in_item_t        in_item;
  vlcr_pkg::out_item_t       out_item;
  vlcr_pkg::bank_cmd_t       bank_cmd;
  vlcr_pkg::bank_stat_t      bank_stat;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_count_q <= vlcr_pkg::ResetRepeat;
    end else if (cfg_if.valid) begin
      repeat_count_q <= cfg_if.repeat_count;
    end
  end

  assign in_item.opcode        = vlcr_pkg::opcode_e'(in_if.opcode);
  assign in_item.light_channel = in_if.light_channel;
  assign in_item.light_value   = in_if.light_value;

  vlcr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_item_i   (in_item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_item),
    .cmd_o       (bank_cmd),
    .stat_i      (bank_stat)
  );

  vlcr_bank u_bank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .repeat_count_i (repeat_count_q),
    .cmd_i          (bank_cmd),
    .stat_o         (bank_stat)
  );

  assign out_if.out_channel  = out_item.out_channel;
  assign out_if.out_value    = out_item.out_value;
  assign out_if.last_of_tick = out_item.last_of_tick;

endmodule

FILE: design/vlcr_bank.sv
// ----------------------------------------------------------------------------
// vlcr_bank
// Light state bits and repeat counters of the six channels, with the one
// shared decrement unit that the tick scan steps across the channels.
// ----------------------------------------------------------------------------
module vlcr_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vlcr_pkg::CntW-1:0]     repeat_count_i,
  input  vlcr_pkg::bank_cmd_t           cmd_i,
  output vlcr_pkg::bank_stat_t          stat_o
);

  logic [vlcr_pkg::NumLights-1:0] lit_q, lit_d;
  logic [vlcr_pkg::CntW-1:0]      cnt_q [vlcr_pkg::NumLights];
  logic [vlcr_pkg::CntW-1:0]      cnt_d [vlcr_pkg::NumLights];
  logic [vlcr_pkg::CntW-1:0]      dec_val;
  logic                           cur_val;
  logic                           ch_valid;
  logic                           changed;
  logic                           grp_req;

  // Shared decrement unit on the channel selected by the scan.
  assign dec_val = cnt_q[cmd_i.dec_idx] - vlcr_pkg::CntW'(1);

  assign ch_valid = (cmd_i.set_ch <= vlcr_pkg::ChLast);
  assign grp_req  = (cmd_i.set_ch == vlcr_pkg::ChRight) ||
                    (cmd_i.set_ch == vlcr_pkg::ChLeft)  ||
                    (cmd_i.set_ch == vlcr_pkg::ChHazard);

  always_comb begin
    cur_val = 1'b0;
    for (int j = 0; j < vlcr_pkg::NumLights; j++) begin
      if (cmd_i.set_ch == vlcr_pkg::ChW'(j)) begin
        cur_val = lit_q[j];
      end
    end
  end

  assign changed = cmd_i.set_en && ch_valid && (cur_val != cmd_i.set_val);

  always_comb begin
    logic nv;
    logic in_grp;
    lit_d = lit_q;
    for (int j = 0; j < vlcr_pkg::NumLights; j++) begin
      cnt_d[j] = cnt_q[j];
      in_grp   = (vlcr_pkg::ChW'(j) == vlcr_pkg::ChRight) ||
                 (vlcr_pkg::ChW'(j) == vlcr_pkg::ChLeft)  ||
                 (vlcr_pkg::ChW'(j) == vlcr_pkg::ChHazard);
      if (cmd_i.set_ch == vlcr_pkg::ChW'(j)) begin
        nv = cmd_i.set_val;
      end else if (grp_req && in_grp) begin
        // Turn right, turn left and hazard exclude one another.
        nv = 1'b0;
      end else begin
        nv = lit_q[j];
      end
      if (changed && (nv != lit_q[j])) begin
        lit_d[j] = nv;
        cnt_d[j] = repeat_count_i;
      end
      if (cmd_i.dec_en && (cmd_i.dec_idx == vlcr_pkg::ChW'(j))) begin
        cnt_d[j] = dec_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q <= '0;
      for (int j = 0; j < vlcr_pkg::NumLights; j++) begin
        cnt_q[j] <= '0;
      end
    end else begin
      lit_q <= lit_d;
      for (int j = 0; j < vlcr_pkg::NumLights; j++) begin
        cnt_q[j] <= cnt_d[j];
      end
    end
  end

  always_comb begin
    stat_o.lit = lit_q;
    for (int j = 0; j < vlcr_pkg::NumLights; j++) begin
      stat_o.nz[j] = (cnt_q[j] != '0);
    end
  end

endmodule

FILE: design/vlcr_seq.sv
// ----------------------------------------------------------------------------
// vlcr_seq
// Sequencer: takes one command, applies a set request to the bank or scans
// the channels one per cycle on a tick, pausing while a result waits, and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module vlcr_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  vlcr_pkg::in_item_t     in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output vlcr_pkg::out_item_t    out_item_o,
  output vlcr_pkg::bank_cmd_t    cmd_o,
  input  vlcr_pkg::bank_stat_t   stat_i
);

  vlcr_pkg::seq_state_e        state_q, state_d;
  logic [vlcr_pkg::ChW-1:0]    idx_q, idx_d;
  vlcr_pkg::in_item_t          item_q;
  vlcr_pkg::out_item_t         res_q;
  logic                        more_after;
  logic                        cur_nz;
  logic                        cur_lit;

  always_comb begin
    more_after = 1'b0;
    cur_nz     = 1'b0;
    cur_lit    = 1'b0;
    for (int j = 0; j < vlcr_pkg::NumLights; j++) begin
      if (vlcr_pkg::ChW'(j) > idx_q) begin
        more_after = more_after | stat_i.nz[j];
      end
      if (vlcr_pkg::ChW'(j) == idx_q) begin
        cur_nz  = stat_i.nz[j];
        cur_lit = stat_i.lit[j];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      vlcr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          if (in_item_i.opcode == vlcr_pkg::OP_TICK) begin
            state_d = vlcr_pkg::ST_SCAN;
          end else begin
            state_d = vlcr_pkg::ST_SET;
          end
        end
      end
      vlcr_pkg::ST_SET: begin
        state_d = vlcr_pkg::ST_IDLE;
      end
      vlcr_pkg::ST_SCAN: begin
        if (cur_nz) begin
          state_d = vlcr_pkg::ST_EMIT;
        end else if (idx_q == vlcr_pkg::ChLast) begin
          state_d = vlcr_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + vlcr_pkg::ChW'(1);
        end
      end
      vlcr_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          if (res_q.last_of_tick) begin
            state_d = vlcr_pkg::ST_IDLE;
          end else begin
            state_d = vlcr_pkg::ST_SCAN;
            idx_d   = idx_q + vlcr_pkg::ChW'(1);
          end
        end
      end
      default: state_d = vlcr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and bank commands.
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.set_en  = 1'b0;
    cmd_o.set_ch  = item_q.light_channel;
    cmd_o.set_val = item_q.light_value;
    cmd_o.dec_en  = 1'b0;
    cmd_o.dec_idx = idx_q;
    unique case (state_q)
      vlcr_pkg::ST_IDLE: in_ready_o   = 1'b1;
      vlcr_pkg::ST_SET:  cmd_o.set_en = 1'b1;
      vlcr_pkg::ST_SCAN: cmd_o.dec_en = cur_nz;
      vlcr_pkg::ST_EMIT: out_valid_o  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vlcr_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == vlcr_pkg::ST_IDLE) && in_valid_i) begin
      item_q <= in_item_i;
    end
    // Only lower channels have been decremented so far, so the look-ahead
    // over higher channels is exact when the beat is captured.
    if ((state_q == vlcr_pkg::ST_SCAN) && cur_nz) begin
      res_q.out_channel  <= idx_q;
      res_q.out_value    <= cur_lit;
      res_q.last_of_tick <= ~more_after;
    end
  end

  assign out_item_o = res_q;

endmodule

FILE: design/vlcr_checker.sv
// ----------------------------------------------------------------------------
// vlcr_checker
// Port-level checks of the light command repeater, bound to the top level.
// ----------------------------------------------------------------------------
module vlcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_opcode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_channel_i,
  input logic       out_last_i
);

  // One command at a time: ready drops after every accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("command accepted while another is in progress");

  // Results appear only while a tick is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("result shown while the block is idle");

  // A set request never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_opcode_i == vlcr_pkg::OP_SET)) |=> !out_valid_i)
    else $error("result after a set request");

  // Nothing follows the last beat of a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> !out_valid_i)
    else $error("result after the last beat of a tick");

  // A stalled result holds its channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_channel_i)))
    else $error("stalled result changed");

endmodule

bind vehicle_light_command_repeater_top vlcr_checker u_vlcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .in_opcode_i   (in_if.opcode),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_channel_i (out_if.out_channel),
  .out_last_i    (out_if.last_of_tick)
);
